### rtl/cac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cac_pkg: shared types and constants of the address claim tracker
// Holds the lookup token that walks the cell row, the update command
// broadcast to the cells and the result record of one transaction.
// ----------------------------------------------------------------------------
package cac_pkg;

    localparam int unsigned ID_W   = 29;
    localparam int unsigned ADDR_W = 8;
    localparam int unsigned NAME_W = 64;

    // PDU format of an address claim frame
    localparam logic [ADDR_W-1:0] CLAIM_PF    = 8'hEE;
    // request-for-address-claim identifier, destination goes in bits 15..8
    localparam logic [ID_W-1:0]   REQ_BASE_ID = 29'h18EA0000;

    // lookup token handed from cell to cell
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] src;
        logic              claim;
        logic [NAME_W-1:0] data;
        logic              hit;
        logic              free_seen;
        logic              hit_claimed;
        logic              hit_requested;
        logic [NAME_W-1:0] hit_name;
    } tok_t;

    // update broadcast to all cells at the end of a scan
    typedef struct packed {
        logic              valid;
        logic              alloc;
        logic              claim;
        logic [ADDR_W-1:0] src;
        logic [NAME_W-1:0] data;
    } cmd_t;

    // one result transaction
    typedef struct packed {
        logic              is_claim;
        logic              send_request;
        logic [ID_W-1:0]   request_id;
        logic [ADDR_W-1:0] request_dest;
        logic              table_full;
        logic              node_claimed;
        logic [NAME_W-1:0] node_name;
    } res_t;

endpackage

### rtl/can_address_claim_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_address_claim_tracker: node table for address claim tracking
// Looks up or allocates an entry per received source address, records
// claimed NAMEs and requests a claim from sources seen for the first time.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one received frame: the 29-bit
//   extended identifier and its eight data bytes. Output channel
//   (out_valid/out_ready) carries one result per frame.
//   The table is a row of TABLE_DEPTH cells, one entry each. A lookup token
//   enters the first cell at acceptance and moves one cell per cycle; the
//   token leaving the last cell updates the matching or lowest free entry
//   and produces the result, which is registered in the output register.
//   No new frame is taken while a scan is in flight.
//   A result waiting in the output register does not block the next frame.
//   If it is still not taken when the next scan finishes, the new result parks
//   in a pending slot and in_ready stays low until the output drains.
//   Reset empties the table: all entries unused, unclaimed, unrequested.
// ----------------------------------------------------------------------------
module can_address_claim_tracker #(
    parameter int unsigned TABLE_DEPTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [cac_pkg::ID_W-1:0]      frame_id,
    input  logic [cac_pkg::NAME_W-1:0]    frame_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          is_claim,
    output logic                          send_request,
    output logic [cac_pkg::ID_W-1:0]      request_id,
    output logic [cac_pkg::ADDR_W-1:0]    request_dest,
    output logic                          table_full,
    output logic                          node_claimed,
    output logic [cac_pkg::NAME_W-1:0]    node_name
);
    import cac_pkg::*;

    tok_t                   tok_chain [TABLE_DEPTH+1];
    cmd_t                   cmd;
    res_t                   res;
    logic [TABLE_DEPTH-1:0] wr_vec;

    // control, token launch and result
    cac_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .frame_id   (frame_id),
        .frame_data (frame_data),
        .head       (tok_chain[0]),
        .tail       (tok_chain[TABLE_DEPTH]),
        .cmd        (cmd),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .res        (res)
    );

    // row of table cells
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        cac_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (tok_chain[i]),
            .tok_out (tok_chain[i+1]),
            .cmd     (cmd),
            .wr_hit  (wr_vec[i])
        );
    end

    assign is_claim     = res.is_claim;
    assign send_request = res.send_request;
    assign request_id   = res.request_id;
    assign request_dest = res.request_dest;
    assign table_full   = res.table_full;
    assign node_claimed = res.node_claimed;
    assign node_name    = res.node_name;

    // an update lands in at most one entry
    a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(wr_vec))
        else $error("table update hit more than one entry");

    // a non-full update always lands in exactly one entry
    a_update_lands: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid |-> $onehot(wr_vec))
        else $error("table update found no entry");

endmodule

### rtl/cac_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cac_cell: one node table entry
// Holds one source entry, compares it against the passing lookup token,
// registers the token for the next cell and applies the update command
// when this entry is the match or the lowest free entry.
// ----------------------------------------------------------------------------
module cac_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  cac_pkg::tok_t tok_in,
    output cac_pkg::tok_t tok_out,
    input  cac_pkg::cmd_t cmd,
    output logic          wr_hit
);
    import cac_pkg::*;

    tok_t              tok_reg;
    tok_t              tok_next;
    logic              used_reg;
    logic [ADDR_W-1:0] source_reg;
    logic [NAME_W-1:0] name_reg;
    logic              claimed_reg;
    logic              requested_reg;
    logic              match_reg;
    logic              first_free_reg;
    logic              match_now;

    // compare the token against this entry and fold in its state
    always_comb
    begin
        match_now = tok_in.valid && used_reg && (source_reg == tok_in.src);
        tok_next  = tok_in;
        if (match_now)
        begin
            tok_next.hit           = 1'b1;
            tok_next.hit_claimed   = claimed_reg;
            tok_next.hit_requested = requested_reg;
            tok_next.hit_name      = name_reg;
        end
        if (!used_reg)
        begin
            tok_next.free_seen = 1'b1;
        end
    end

    // this entry takes the update when it matched or is the first free one
    assign wr_hit  = cmd.valid && (cmd.alloc ? first_free_reg : match_reg);
    assign tok_out = tok_reg;

    // advance token and latch this entry's role in the scan
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg        <= '0;
            match_reg      <= 1'b0;
            first_free_reg <= 1'b0;
        end
        else
        begin
            tok_reg <= tok_next;
            if (tok_in.valid)
            begin
                match_reg      <= match_now;
                first_free_reg <= !used_reg && !tok_in.free_seen;
            end
        end
    end

    // entry flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= 1'b0;
            claimed_reg   <= 1'b0;
            requested_reg <= 1'b0;
        end
        else if (wr_hit)
        begin
            used_reg <= 1'b1;
            if (cmd.alloc)
            begin
                claimed_reg   <= cmd.claim;
                requested_reg <= !cmd.claim;
            end
            else if (cmd.claim)
            begin
                claimed_reg <= 1'b1;
            end
            else
            begin
                requested_reg <= 1'b1;
            end
        end
    end

    // entry payload
    always_ff @(posedge clk)
    begin
        if (wr_hit)
        begin
            source_reg <= cmd.src;
            if (cmd.claim)
            begin
                name_reg <= cmd.data;
            end
        end
    end

endmodule

### rtl/cac_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cac_ctrl: transaction control of the address claim tracker
// Launches a lookup token into the cell row, turns the token leaving the
// last cell into the table update and the result, and holds the result in
// an output register with a pending slot behind it.
// ----------------------------------------------------------------------------
module cac_ctrl (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [cac_pkg::ID_W-1:0]         frame_id,
    input  logic [cac_pkg::NAME_W-1:0]       frame_data,
    output cac_pkg::tok_t                    head,
    input  cac_pkg::tok_t                    tail,
    output cac_pkg::cmd_t                    cmd,
    output logic                             out_valid,
    input  logic                             out_ready,
    output cac_pkg::res_t                    res
);
    import cac_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_WAIT = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    res_t   res_reg;
    res_t   pend_reg;
    res_t   res_now;
    logic   out_valid_reg;
    logic   out_free;
    logic   full;
    logic   known_claimed;

    assign in_ready = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || out_ready;

    // build the lookup token from the accepted frame
    always_comb
    begin
        head       = '0;
        head.valid = in_valid && in_ready;
        head.src   = frame_id[ADDR_W-1:0];
        head.claim = (frame_id[23:16] == CLAIM_PF);
        head.data  = frame_data;
    end

    // table update from the finished scan
    always_comb
    begin
        full      = !tail.hit && !tail.free_seen;
        cmd.valid = tail.valid && !full;
        cmd.alloc = !tail.hit;
        cmd.claim = tail.claim;
        cmd.src   = tail.src;
        cmd.data  = tail.data;
    end

    // result of the finished scan
    always_comb
    begin
        known_claimed        = tail.hit && tail.hit_claimed;
        res_now              = '0;
        res_now.is_claim     = tail.claim;
        res_now.table_full   = full;
        res_now.send_request = !tail.claim && !full && !(tail.hit && tail.hit_requested);
        if (res_now.send_request)
        begin
            res_now.request_id   = REQ_BASE_ID | {{(ID_W-2*ADDR_W){1'b0}}, tail.src,
                                                  {ADDR_W{1'b0}}};
            res_now.request_dest = tail.src;
        end
        res_now.node_claimed = !full && (tail.claim || known_claimed);
        if (!full && tail.claim)
        begin
            res_now.node_name = tail.data;
        end
        else if (!full && known_claimed)
        begin
            res_now.node_name = tail.hit_name;
        end
    end

    // sequence one transaction at a time
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (tail.valid)
                begin
                    state_next = out_free ? ST_IDLE : ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == ST_SCAN && tail.valid) || state_reg == ST_WAIT)
            begin
                if (out_free)
                begin
                    out_valid_reg <= 1'b1;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // load output register, or park the result while the receiver stalls
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SCAN && tail.valid)
        begin
            if (out_free)
            begin
                res_reg <= res_now;
            end
            else
            begin
                pend_reg <= res_now;
            end
        end
        else if (state_reg == ST_WAIT && out_free)
        begin
            res_reg <= pend_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign res       = res_reg;

    // a scan only finishes while one is in flight
    a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        tail.valid |-> (state_reg == ST_SCAN))
        else $error("lookup token left the row outside a scan");

    // a full table never asks for a claim and reports no node
    a_full_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.table_full) |->
            (!res_reg.send_request && !res_reg.node_claimed))
        else $error("full table result carries a request or node");

    // request destination matches the identifier's destination byte
    a_req_dest: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.send_request) |->
            (res_reg.request_id[15:8] == res_reg.request_dest))
        else $error("request destination differs from identifier");

endmodule

### test/cac_claim_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cac_claim_checker: result checker for the address claim tracker
// Watches both channels of the tracker. Every frame transaction updates a
// private copy of the node table and queues the report that the block
// should give for it; every result transaction is compared field by field
// with the oldest queued report.
// ----------------------------------------------------------------------------
module cac_claim_checker #(
    parameter int unsigned TABLE_DEPTH = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic [cac_pkg::ID_W-1:0]   frame_id,
    input  logic [cac_pkg::NAME_W-1:0] frame_data,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic                       is_claim,
    input  logic                       send_request,
    input  logic [cac_pkg::ID_W-1:0]   request_id,
    input  logic [cac_pkg::ADDR_W-1:0] request_dest,
    input  logic                       table_full,
    input  logic                       node_claimed,
    input  logic [cac_pkg::NAME_W-1:0] node_name,
    output int                         fail_count,
    output int                         open_count
);
    import cac_pkg::*;

    // private node table
    logic              entry_used      [TABLE_DEPTH];
    logic [ADDR_W-1:0] entry_src       [TABLE_DEPTH];
    logic [NAME_W-1:0] entry_name      [TABLE_DEPTH];
    logic              entry_claimed   [TABLE_DEPTH];
    logic              entry_requested [TABLE_DEPTH];

    // reports owed by the block, oldest first
    res_t node_reports[$];
    int   errors = 0;

    assign fail_count = errors;

    // compare one field of a result, flag X as a mismatch too
    task automatic check_field(input string field, input logic [NAME_W-1:0] want,
                               input logic [NAME_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            errors++;
        end
    endtask

    // look up or allocate the source entry, apply the frame, build the report
    task automatic update_node_table(input logic [ID_W-1:0] id,
                                     input logic [NAME_W-1:0] data,
                                     output res_t rep);
        logic [ADDR_W-1:0] src;
        logic              claim;
        logic              send;
        int                slot;
        src   = id[ADDR_W-1:0];
        claim = (id[23:16] == CLAIM_PF);
        send  = 1'b0;
        slot  = -1;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (slot < 0 && entry_used[i] && entry_src[i] == src)
                slot = i;
        end
        // unknown source: take the lowest free entry
        if (slot < 0)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                if (slot < 0 && !entry_used[i])
                begin
                    slot               = i;
                    entry_used[i]      = 1'b1;
                    entry_src[i]       = src;
                    entry_name[i]      = '0;
                    entry_claimed[i]   = 1'b0;
                    entry_requested[i] = 1'b0;
                end
            end
        end
        if (slot >= 0)
        begin
            if (claim)
            begin
                entry_name[slot]    = data;
                entry_claimed[slot] = 1'b1;
            end
            else if (!entry_requested[slot])
            begin
                entry_requested[slot] = 1'b1;
                send                  = 1'b1;
            end
        end
        rep              = '0;
        rep.is_claim     = claim;
        rep.send_request = send;
        if (send)
        begin
            rep.request_id   = REQ_BASE_ID | {{(ID_W-ADDR_W-8){1'b0}}, src, 8'h00};
            rep.request_dest = src;
        end
        rep.table_full = (slot < 0);
        if (slot >= 0 && entry_claimed[slot])
        begin
            rep.node_claimed = 1'b1;
            rep.node_name    = entry_name[slot];
        end
    endtask

    // predict on each frame transaction, compare on each result transaction
    always @(posedge clk or negedge rst_n)
    begin : watch
        res_t rep;
        res_t due;
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                entry_used[i]      = 1'b0;
                entry_claimed[i]   = 1'b0;
                entry_requested[i] = 1'b0;
            end
            node_reports.delete();
            open_count <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                update_node_table(frame_id, frame_data, rep);
                node_reports.push_back(rep);
            end
            if (out_valid && out_ready)
            begin
                if (node_reports.size() == 0)
                begin
                    $error("result transaction with no frame outstanding");
                    errors++;
                end
                else
                begin
                    due = node_reports.pop_front();
                    check_field("is_claim", NAME_W'(due.is_claim), NAME_W'(is_claim));
                    check_field("send_request", NAME_W'(due.send_request),
                                NAME_W'(send_request));
                    check_field("request_id", NAME_W'(due.request_id),
                                NAME_W'(request_id));
                    check_field("request_dest", NAME_W'(due.request_dest),
                                NAME_W'(request_dest));
                    check_field("table_full", NAME_W'(due.table_full),
                                NAME_W'(table_full));
                    check_field("node_claimed", NAME_W'(due.node_claimed),
                                NAME_W'(node_claimed));
                    check_field("node_name", due.node_name, node_name);
                end
            end
            open_count <= node_reports.size();
        end
    end

endmodule

### test/tb_can_address_claim_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_can_address_claim_tracker: testbench of the address claim tracker
// Drives received frames into the tracker: a directed run over the edge
// values, repeated and first-seen sources and a full table, then random
// frames drawn mostly from the known sources. Both channels idle in random
// bursts and the result side holds off once for a long stretch. The
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_can_address_claim_tracker;
    import cac_pkg::*;

    localparam int TABLE_DEPTH  = 16;
    localparam int RANDOM_ITEMS = 800;
    localparam int QUIET_ITEMS  = 100;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int LONG_HOLD_AT = 3000;
    localparam int LONG_HOLD    = 400;

    // plain PDU formats used besides the claim
    localparam logic [7:0] PF_REQUEST     = 8'hEA;
    localparam logic [7:0] PF_PROPRIETARY = 8'hFF;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [ID_W-1:0]   frame_id;
    logic [NAME_W-1:0] frame_data;
    logic              out_valid;
    logic              out_ready;
    logic              is_claim;
    logic              send_request;
    logic [ID_W-1:0]   request_id;
    logic [ADDR_W-1:0] request_dest;
    logic              table_full;
    logic              node_claimed;
    logic [NAME_W-1:0] node_name;
    int                fail_count;
    int                open_count;

    int   cycle_count = 0;
    bit   quiet       = 1'b0;
    logic [7:0] known_src [TABLE_DEPTH];

    can_address_claim_tracker #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .frame_id     (frame_id),
        .frame_data   (frame_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .is_claim     (is_claim),
        .send_request (send_request),
        .request_id   (request_id),
        .request_dest (request_dest),
        .table_full   (table_full),
        .node_claimed (node_claimed),
        .node_name    (node_name)
    );

    cac_claim_checker #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .frame_id     (frame_id),
        .frame_data   (frame_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .is_claim     (is_claim),
        .send_request (send_request),
        .request_id   (request_id),
        .request_dest (request_dest),
        .table_full   (table_full),
        .node_claimed (node_claimed),
        .node_name    (node_name),
        .fail_count   (fail_count),
        .open_count   (open_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // assemble priority/data page, PDU format, PDU specific and source
    function automatic logic [ID_W-1:0] make_id(input logic [4:0] head, input logic [7:0] pf,
                                                input logic [7:0] ps, input logic [7:0] sa);
        return {head, pf, ps, sa};
    endfunction

    // offer one frame, optionally after an idle burst, and hold it until taken
    task automatic send_frame(input logic [ID_W-1:0] id, input logic [NAME_W-1:0] data);
        if (!quiet && $urandom_range(0, 2) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        frame_id   <= id;
        frame_data <= data;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // result side: random stalls, one long hold-off, none in the quiet tail
    initial
    begin : receiver
        int n;
        int waited;
        bit long_done;
        out_ready = 1'b0;
        waited    = 0;
        long_done = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (!long_done && waited >= LONG_HOLD_AT)
            begin
                long_done = 1'b1;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                waited += LONG_HOLD;
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                n = $urandom_range(1, 15);
                out_ready <= 1'b0;
                repeat (n) @(posedge clk);
                waited += n;
            end
            else
            begin
                n = $urandom_range(1, 20);
                out_ready <= 1'b1;
                repeat (n) @(posedge clk);
                waited += n;
            end
        end
    end

    // stimulus and verdict
    initial
    begin : stimulus
        logic [7:0]        src;
        logic [7:0]        pf;
        logic [NAME_W-1:0] data;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        frame_id   = '0;
        frame_data = '0;
        known_src  = '{8'h00, 8'hFF, 8'hFE, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
                       8'h20, 8'h40, 8'h80, 8'h55, 8'hAA, 8'h33, 8'hCC, 8'h0F};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // all-zero and all-one identifiers, then a repeat that asks nothing
        send_frame('0, '0);
        send_frame({ID_W{1'b1}}, {NAME_W{1'b1}});
        send_frame({ID_W{1'b1}}, 64'h0123_4567_89AB_CDEF);
        // claims on a requested entry, NAME of all ones then zero
        send_frame(make_id(5'h18, CLAIM_PF, 8'hFF, 8'h00), {NAME_W{1'b1}});
        send_frame(make_id(5'h18, CLAIM_PF, 8'hFF, 8'h00), '0);
        send_frame(make_id(5'h18, PF_REQUEST, 8'h00, 8'h00), 64'hA5A5_5A5A_F0F0_0F0F);
        // claim on a new entry, then its first and second plain frame
        send_frame(make_id(5'h06, CLAIM_PF, 8'hFF, 8'hFE), 64'hDEAD_BEEF_CAFE_F00D);
        send_frame(make_id(5'h06, PF_REQUEST, 8'hFE, 8'hFE), {$urandom, $urandom});
        send_frame(make_id(5'h06, PF_PROPRIETARY, 8'h12, 8'hFE), {$urandom, $urandom});
        send_frame(make_id(5'h1F, CLAIM_PF, 8'hFF, 8'hFF), 64'h8000_0000_0000_0001);
        // fill the rest of the table, claims and plain frames alternating
        for (int i = 3; i < TABLE_DEPTH; i++)
        begin
            pf = i[0] ? CLAIM_PF : PF_REQUEST;
            send_frame(make_id(5'($urandom), pf, 8'($urandom), known_src[i]),
                       {$urandom, $urandom});
        end
        // unknown sources on a full table
        send_frame(make_id(5'h18, PF_REQUEST, 8'h77, 8'h77), {$urandom, $urandom});
        send_frame(make_id(5'h18, CLAIM_PF, 8'hFF, 8'h88), {$urandom, $urandom});

        // random frames, mostly on known sources
        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k >= RANDOM_ITEMS - QUIET_ITEMS)
                quiet = 1'b1;
            src = ($urandom_range(0, 3) != 0) ? known_src[$urandom_range(0, TABLE_DEPTH - 1)]
                                              : 8'($urandom);
            pf  = ($urandom_range(0, 9) < 4) ? CLAIM_PF : 8'($urandom);
            case ($urandom_range(0, 7))
                0:       data = '0;
                1:       data = {NAME_W{1'b1}};
                default: data = {$urandom, $urandom};
            endcase
            send_frame(make_id(5'($urandom), pf, 8'($urandom), src), data);
        end

        // drain every owed result, then let the pipeline settle
        in_valid <= 1'b0;
        @(posedge clk);
        while (open_count != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
